FILE: rtl/stpv_pkg.sv
// ----------------------------------------------------------------------------
// stpv_pkg
// shared constants and types for the sorted table with prime view
// ----------------------------------------------------------------------------
`default_nettype none
package stpv_pkg;
   localparam int DEFAULT_DEPTH = 256;
   localparam int VAL_W = 32;
   localparam int FUNC_W = 3;
   localparam int POS_W = 8;
   localparam int ST_W = 2;
   localparam int CNT_W = 9;

   localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ_ASC = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_READ_SIDE = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_READ_PRIME = 3'd4;

   localparam logic [ST_W-1:0] ST_OK = 2'd0;
   localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [ST_W-1:0] ST_RANGE = 2'd2;
   localparam logic [ST_W-1:0] ST_FULL = 2'd3;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture request word
      logic scan_rd;    // issue read at scan index
      logic scan_step;  // advance scan index
      logic prime_start;
      logic shift_rd;   // read neighbor for shift
      logic shift_wr;   // write shifted entry
      logic ins_wr;     // write new entry at insert point
      logic commit_ins;
      logic commit_rem;
      logic direct_rd;  // read at mapped position
      logic finish;     // build response word
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic full;
      logic scan_done;   // scan index reached fill count
      logic scan_hit;    // registered read data matches
      logic prime_done;
      logic shift_done;
      logic direct_ok;
   } sts_type;
endpackage
`default_nettype wire

FILE: rtl/sorted_table_with_prime_view_top.sv
// a scan takes a read and a check state per entry, a shift a read and a write
// state per entry; an insert also waits for its primality test, one division per
// trial divisor, run beside the shift; one word at a time; the single port entry
// memory and divider set the rate; ascending and side-cross reads do a direct read
// synchronous active high reset empties the table at once; entries need no clear
`default_nettype none
module sorted_table_with_prime_view_top
   import stpv_pkg::*;
#(
   parameter int DEPTH = DEFAULT_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [FUNC_W-1:0] req_func,
   input  wire logic [VAL_W-1:0]  req_value,
   input  wire logic [POS_W-1:0]  req_position,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [VAL_W-1:0]       rsp_read_value,
   output logic [ST_W-1:0]        rsp_status,
   output logic [CNT_W-1:0]       rsp_entry_count,
   output logic [CNT_W-1:0]       rsp_prime_count
);
   ctl_type ctl;
   sts_type sts;

   stpv_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .ctl(ctl), .sts(sts)
   );

   stpv_datapath #(.DEPTH(DEPTH)) u_dp (
      .clock(clock), .reset(reset), .ctl(ctl), .sts(sts),
      .req_func(req_func), .req_value(req_value), .req_position(req_position),
      .rsp_read_value(rsp_read_value), .rsp_status(rsp_status),
      .rsp_entry_count(rsp_entry_count), .rsp_prime_count(rsp_prime_count)
   );
endmodule
`default_nettype wire

FILE: rtl/stpv_ram.sv
// ----------------------------------------------------------------------------
// stpv_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none
module stpv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule
`default_nettype wire

FILE: rtl/stpv_prime.sv
// ----------------------------------------------------------------------------
// stpv_prime
// trial division primality test, one restoring division bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module stpv_prime
   import stpv_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [VAL_W-1:0] value,
   output logic                  done,
   output logic                  is_prime
);
   typedef enum logic [3:0] {
      P_IDLE = 4'b0001,
      P_SQ   = 4'b0010,
      P_DIV  = 4'b0100,
      P_DONE = 4'b1000
   } pstate_type;

   pstate_type        state_ff, state_in;
   logic [31:0]       n_ff;
   logic [16:0]       d_ff;
   logic [33:0]       sq_ff;
   logic [31:0]       rem_ff;
   logic [31:0]       quo_ff;
   logic [5:0]        bit_ff;
   logic              prime_ff;
   logic [32:0]       trial;
   logic [31:0]       rem_next;

   // done and the verdict hold until the next start
   assign done = (state_ff == P_DONE);
   assign is_prime = prime_ff;
   assign trial = {rem_ff, quo_ff[31]} - {16'd0, d_ff};
   assign rem_next = trial[32] ? {rem_ff[30:0], quo_ff[31]} : trial[31:0];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         P_IDLE, P_DONE: if (start) state_in = P_SQ;
         P_SQ: begin
            if (n_ff[31] || n_ff <= 32'd1) state_in = P_DONE;
            else if (sq_ff > {2'b00, n_ff}) state_in = P_DONE;
            else state_in = P_DIV;
         end
         P_DIV: begin
            if (bit_ff == 6'd0) state_in = (rem_next == 32'd0) ? P_DONE : P_SQ;
         end
         default: state_in = P_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= P_IDLE;
      end else begin
         state_ff <= state_in;
      end
      unique case (state_ff)
         P_IDLE, P_DONE: if (start) begin
            n_ff <= value;
            d_ff <= 17'd2;
            sq_ff <= 34'd4;
            prime_ff <= 1'b0;
         end
         P_SQ: begin
            if (n_ff[31] || n_ff <= 32'd1) prime_ff <= 1'b0;
            else if (sq_ff > {2'b00, n_ff}) prime_ff <= 1'b1;
            rem_ff <= 32'd0;
            quo_ff <= n_ff;
            bit_ff <= 6'd31;
         end
         P_DIV: begin
            rem_ff <= rem_next;
            quo_ff <= {quo_ff[30:0], 1'b0};
            bit_ff <= bit_ff - 6'd1;
            if (bit_ff == 6'd0) begin
               if (rem_next == 32'd0) prime_ff <= 1'b0;
               d_ff <= d_ff + 17'd1;
               sq_ff <= sq_ff + {16'd0, d_ff, 1'b0} + 34'd1;
            end
         end
         default: ;
      endcase
   end
endmodule
`default_nettype wire

FILE: rtl/stpv_datapath.sv
// ----------------------------------------------------------------------------
// stpv_datapath
// entry memory, scan and shift pointers, counters and response word
// ----------------------------------------------------------------------------
`default_nettype none
module stpv_datapath
   import stpv_pkg::*;
#(
   parameter int DEPTH = DEFAULT_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ctl_type           ctl,
   output sts_type                sts,
   input  wire logic [FUNC_W-1:0] req_func,
   input  wire logic [VAL_W-1:0]  req_value,
   input  wire logic [POS_W-1:0]  req_position,
   output logic [VAL_W-1:0]       rsp_read_value,
   output logic [ST_W-1:0]        rsp_status,
   output logic [CNT_W-1:0]       rsp_entry_count,
   output logic [CNT_W-1:0]       rsp_prime_count
);
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [FUNC_W-1:0] func_ff;
   logic [VAL_W-1:0]  val_ff;
   logic [POS_W-1:0]  pos_ff;
   logic [CW-1:0]     fill_ff, primes_ff;
   logic [CW-1:0]     idx_ff;      // scan index
   logic [CW-1:0]     seen_ff;     // primes passed
   logic [CW-1:0]     sh_ff;       // shift pointer
   logic              ok_ff;
   logic [CW-1:0]     map_idx;
   logic              map_ok;
   logic              rem_prime_ff;
   logic              sh_dir_ff;
   logic [VAL_W-1:0]  rv_in;
   logic [ST_W-1:0]   st_in;

   logic              we;
   logic [AW-1:0]     addr;
   logic [VAL_W:0]    wdata, rdata, hold_ff;
   logic              p_done, p_prime;

   stpv_ram #(.WIDTH(VAL_W + 1), .DEPTH(DEPTH)) u_ram (
      .clock(clock), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
   );

   stpv_prime u_prime (
      .clock(clock), .reset(reset), .start(ctl.prime_start), .value(val_ff),
      .done(p_done), .is_prime(p_prime)
   );

   logic [CW-1:0] pos_w, half_w;
   assign pos_w  = CW'(pos_ff);
   assign half_w = CW'(pos_ff[POS_W-1:1]);

   always_comb begin
      map_ok = 1'b0;
      map_idx = '0;
      unique case (func_ff)
         FUNC_READ_ASC: begin
            map_ok = 32'(pos_ff) < 32'(fill_ff);
            map_idx = pos_w;
         end
         FUNC_READ_SIDE: begin
            map_ok = 32'(pos_ff[POS_W-1:1]) < 32'(fill_ff);
            map_idx = pos_ff[0] ? fill_ff - CW'(1) - half_w : half_w;
         end
         default: ;
      endcase
   end

   // scan hit: insert stops at first not-less, remove at first equal,
   // prime read at the wanted flagged entry
   logic hit;
   always_comb begin
      unique case (func_ff)
         FUNC_INSERT: hit = ({~rdata[31], rdata[30:0]} >= {~val_ff[31], val_ff[30:0]});
         FUNC_REMOVE: hit = (rdata[VAL_W-1:0] == val_ff);
         default:     hit = rdata[VAL_W] && (32'(seen_ff) == 32'(pos_ff));
      endcase
   end

   assign sts.func = func_ff;
   assign sts.full = (fill_ff == CW'(DEPTH));
   assign sts.scan_done = (idx_ff >= fill_ff);
   assign sts.scan_hit = hit;
   assign sts.prime_done = p_done;
   assign sts.shift_done = sh_dir_ff ? (sh_ff <= idx_ff) : (sh_ff + CW'(1) >= fill_ff);
   assign sts.direct_ok = map_ok;

   always_comb begin
      we = 1'b0;
      wdata = hold_ff;
      addr = AW'(idx_ff);
      if (ctl.direct_rd) addr = AW'(map_idx);
      if (ctl.shift_rd) addr = sh_dir_ff ? AW'(sh_ff - CW'(1)) : AW'(sh_ff + CW'(1));
      if (ctl.shift_wr) begin
         we = 1'b1;
         addr = AW'(sh_ff);
         wdata = rdata;
      end
      if (ctl.ins_wr) begin
         we = 1'b1;
         addr = AW'(idx_ff);
         wdata = {p_prime, val_ff};
      end
   end

   // response word
   always_comb begin
      rv_in = '0;
      st_in = ST_OK;
      unique case (func_ff)
         FUNC_INSERT: if (!ok_ff) st_in = ST_FULL;
         FUNC_REMOVE: if (!ok_ff) st_in = ST_NOT_FOUND;
         FUNC_READ_ASC, FUNC_READ_SIDE, FUNC_READ_PRIME: begin
            if (ok_ff) rv_in = rdata[VAL_W-1:0];
            else st_in = ST_RANGE;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         primes_ff <= '0;
      end else begin
         if (ctl.commit_ins) begin
            fill_ff <= fill_ff + CW'(1);
            if (p_prime) primes_ff <= primes_ff + CW'(1);
         end
         if (ctl.commit_rem) begin
            fill_ff <= fill_ff - CW'(1);
            if (rem_prime_ff) primes_ff <= primes_ff - CW'(1);
         end
      end
      if (ctl.load) begin
         func_ff <= req_func;
         val_ff <= req_value;
         pos_ff <= req_position;
         idx_ff <= '0;
         seen_ff <= '0;
         ok_ff <= 1'b0;
      end
      if (ctl.scan_step) begin
         idx_ff <= idx_ff + CW'(1);
         if (rdata[VAL_W]) seen_ff <= seen_ff + CW'(1);
      end
      if (ctl.scan_rd && !ctl.scan_step) begin
         // hit, or insert scan at end of table, registered: set up shift
         hold_ff <= rdata;
         rem_prime_ff <= rdata[VAL_W];
         ok_ff <= 1'b1;
         sh_dir_ff <= (func_ff == FUNC_INSERT);
         sh_ff <= (func_ff == FUNC_INSERT) ? fill_ff : idx_ff;
      end
      if (ctl.shift_wr) sh_ff <= sh_dir_ff ? sh_ff - CW'(1) : sh_ff + CW'(1);
      if (ctl.direct_rd) ok_ff <= map_ok;
      if (ctl.finish) begin
         rsp_read_value <= rv_in;
         rsp_status <= st_in;
      end
   end

   assign rsp_entry_count = CNT_W'(fill_ff);
   assign rsp_prime_count = CNT_W'(primes_ff);
endmodule
`default_nettype wire

FILE: rtl/stpv_ctrl.sv
// ----------------------------------------------------------------------------
// stpv_ctrl
// sequencer for scan, shift, primality test and response handshake
// ----------------------------------------------------------------------------
`default_nettype none
module stpv_ctrl
   import stpv_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_ready,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   output ctl_type   ctl,
   input  wire sts_type sts
);
   typedef enum logic [10:0] {
      S_IDLE   = 11'b00000000001,
      S_DISP   = 11'b00000000010,
      S_SRD    = 11'b00000000100,
      S_SCHK   = 11'b00000001000,
      S_PRIME  = 11'b00000010000,
      S_SHRD   = 11'b00000100000,
      S_SHWR   = 11'b00001000000,
      S_INS    = 11'b00010000000,
      S_DRD    = 11'b00100000000,
      S_FIN    = 11'b01000000000,
      S_RSP    = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RSP);

   always_comb begin
      state_in = state_ff;
      ctl = '0;
      unique case (state_ff)
         S_IDLE: if (req_valid) begin
            ctl.load = 1'b1;
            state_in = S_DISP;
         end
         S_DISP: begin
            unique case (sts.func)
               FUNC_INSERT: state_in = sts.full ? S_FIN : S_SRD;
               FUNC_REMOVE, FUNC_READ_PRIME: state_in = S_SRD;
               FUNC_READ_ASC, FUNC_READ_SIDE: state_in = S_DRD;
               default: state_in = S_FIN;
            endcase
         end
         S_SRD: begin
            if (sts.scan_done) begin
               if (sts.func == FUNC_INSERT) begin
                  ctl.prime_start = 1'b1;
                  ctl.scan_rd = 1'b1;
                  state_in = S_PRIME;
               end else state_in = S_FIN;
            end else state_in = S_SCHK;
         end
         S_SCHK: begin
            ctl.scan_rd = 1'b1;
            if (sts.scan_hit) begin
               if (sts.func == FUNC_INSERT) begin
                  ctl.prime_start = 1'b1;
                  state_in = S_PRIME;
               end else if (sts.func == FUNC_REMOVE) state_in = S_SHRD;
               else state_in = S_FIN;
            end else begin
               ctl.scan_step = 1'b1;
               state_in = S_SRD;
            end
         end
         S_PRIME: state_in = S_SHRD;
         S_SHRD: begin
            if (sts.shift_done) begin
               state_in = (sts.func == FUNC_INSERT) ? S_INS : S_FIN;
               if (sts.func == FUNC_REMOVE) ctl.commit_rem = 1'b1;
            end else begin
               ctl.shift_rd = 1'b1;
               state_in = S_SHWR;
            end
         end
         S_SHWR: begin
            ctl.shift_wr = 1'b1;
            state_in = S_SHRD;
         end
         S_INS: if (sts.prime_done) begin
            ctl.ins_wr = 1'b1;
            ctl.commit_ins = 1'b1;
            state_in = S_FIN;
         end
         S_DRD: begin
            ctl.direct_rd = 1'b1;
            state_in = S_FIN;
         end
         S_FIN: begin
            ctl.finish = 1'b1;
            state_in = S_RSP;
         end
         S_RSP: if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

FILE: rtl/stpv_checker.sv
// ----------------------------------------------------------------------------
// stpv_checker
// port level checks on the table
// ----------------------------------------------------------------------------
`default_nettype none
module stpv_checker
   import stpv_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire logic [VAL_W-1:0] rsp_read_value,
   input wire logic [ST_W-1:0]  rsp_status,
   input wire logic [CNT_W-1:0] rsp_entry_count,
   input wire logic [CNT_W-1:0] rsp_prime_count
);
   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value))
      else $error("response changed while stalled");
   a_primes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_prime_count <= rsp_entry_count)
      else $error("more primes than entries");
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_read_value == '0)
      else $error("value on failed word");
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("accepting while response pending");
endmodule

bind sorted_table_with_prime_view_top stpv_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_read_value(rsp_read_value),
   .rsp_status(rsp_status), .rsp_entry_count(rsp_entry_count),
   .rsp_prime_count(rsp_prime_count)
);
`default_nettype wire

FILE: tb/sorted_table_with_prime_view_checker.sv
// ----------------------------------------------------------------------------
// sorted_table_with_prime_view_checker
// watches the request and response channels, keeps its own copy of the sorted
// table with prime flags, predicts every response word and compares it
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module sorted_table_with_prime_view_checker
   import stpv_pkg::*;
#(
   parameter int DEPTH = DEFAULT_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_ready,
   input  wire logic [FUNC_W-1:0] req_func,
   input  wire logic [VAL_W-1:0]  req_value,
   input  wire logic [POS_W-1:0]  req_position,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_ready,
   input  wire logic [VAL_W-1:0]  rsp_read_value,
   input  wire logic [ST_W-1:0]   rsp_status,
   input  wire logic [CNT_W-1:0]  rsp_entry_count,
   input  wire logic [CNT_W-1:0]  rsp_prime_count,
   output int                     mismatches,
   output int                     pending
);
   typedef struct packed {
      logic [VAL_W-1:0] read_value;
      logic [ST_W-1:0]  status;
      logic [CNT_W-1:0] entry_count;
      logic [CNT_W-1:0] prime_count;
   } answer_type;

   logic [VAL_W-1:0] table_vals [DEPTH];
   bit               table_prime [DEPTH];
   int               held;
   int               primes;
   answer_type       answers_due [$];

   function automatic bit trial_prime(logic [VAL_W-1:0] bits);
      logic [63:0] n;
      logic [63:0] d;
      if (bits[VAL_W-1]) return 0;
      n = {32'd0, bits};
      if (n <= 1) return 0;
      for (d = 2; d * d <= n; d++) begin
         if (n % d == 0) return 0;
      end
      return 1;
   endfunction

   function automatic answer_type table_op(logic [FUNC_W-1:0] func, logic [VAL_W-1:0] val,
                                           logic [POS_W-1:0] pos);
      answer_type a;
      int at;
      int idx;
      int seen;
      a = '0;
      a.status = ST_OK;
      case (func)
         FUNC_INSERT: begin
            if (held >= DEPTH) begin
               a.status = ST_FULL;
            end else begin
               at = 0;
               while (at < held && $signed(table_vals[at]) < $signed(val)) at++;
               for (idx = held; idx > at; idx--) begin
                  table_vals[idx] = table_vals[idx-1];
                  table_prime[idx] = table_prime[idx-1];
               end
               table_vals[at] = val;
               table_prime[at] = trial_prime(val);
               if (table_prime[at]) primes++;
               held++;
            end
         end
         FUNC_REMOVE: begin
            at = 0;
            while (at < held && table_vals[at] != val) at++;
            if (at >= held) begin
               a.status = ST_NOT_FOUND;
            end else begin
               if (table_prime[at]) primes--;
               for (idx = at; idx + 1 < held; idx++) begin
                  table_vals[idx] = table_vals[idx+1];
                  table_prime[idx] = table_prime[idx+1];
               end
               held--;
            end
         end
         FUNC_READ_ASC: begin
            if (pos < held) a.read_value = table_vals[pos];
            else a.status = ST_RANGE;
         end
         FUNC_READ_SIDE: begin
            idx = pos >> 1;
            if (idx < held) a.read_value = pos[0] ? table_vals[held-1-idx] : table_vals[idx];
            else a.status = ST_RANGE;
         end
         FUNC_READ_PRIME: begin
            if (pos < primes) begin
               seen = 0;
               for (idx = 0; idx < held; idx++) begin
                  if (table_prime[idx]) begin
                     if (seen == pos) begin
                        a.read_value = table_vals[idx];
                        break;
                     end
                     seen++;
                  end
               end
            end else begin
               a.status = ST_RANGE;
            end
         end
         default: ;
      endcase
      a.entry_count = held[CNT_W-1:0];
      a.prime_count = primes[CNT_W-1:0];
      return a;
   endfunction

   task automatic report(string what, logic [31:0] want, logic [31:0] got);
      $display("mismatch %s: expected %0h got %0h at %0t", what, want, got, $realtime);
      mismatches++;
   endtask

   initial begin
      mismatches = 0;
      held = 0;
      primes = 0;
   end

   assign pending = answers_due.size();

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         held = 0;
         primes = 0;
         answers_due.delete();
      end else begin
         if (req_valid && req_ready)
            answers_due = {answers_due, table_op(req_func, req_value, req_position)};
         if (rsp_valid && rsp_ready) begin
            if (answers_due.size() == 0) begin
               report("unexpected word", '0, 32'(rsp_status));
            end else begin
               want = answers_due.pop_front();
               if (rsp_read_value !== want.read_value)
                  report("read_value", want.read_value, rsp_read_value);
               if (rsp_status !== want.status)
                  report("status", 32'(want.status), 32'(rsp_status));
               if (rsp_entry_count !== want.entry_count)
                  report("entry_count", 32'(want.entry_count), 32'(rsp_entry_count));
               if (rsp_prime_count !== want.prime_count)
                  report("prime_count", 32'(want.prime_count), 32'(rsp_prime_count));
            end
         end
      end
   end
endmodule
`default_nettype wire

FILE: tb/tb_sorted_table_with_prime_view_top.sv
// ----------------------------------------------------------------------------
// tb_sorted_table_with_prime_view_top
// drives table operations in random bursts: a directed opening, then phases
// that grow, shrink and refill the table; the checker judges every word
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb_sorted_table_with_prime_view_top;
   import stpv_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_SPARE_A = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_B = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_C = 3'd7;
   localparam int RANDOM_WORDS = 1730;
   localparam longint CYCLE_LIMIT = 40_000_000;

   logic              clock = 0;
   logic              reset = 1;
   logic              req_valid = 0;
   logic              req_ready;
   logic [FUNC_W-1:0] req_func = '0;
   logic [VAL_W-1:0]  req_value = '0;
   logic [POS_W-1:0]  req_position = '0;
   logic              rsp_valid;
   logic              rsp_ready = 0;
   logic [VAL_W-1:0]  rsp_read_value;
   logic [ST_W-1:0]   rsp_status;
   logic [CNT_W-1:0]  rsp_entry_count;
   logic [CNT_W-1:0]  rsp_prime_count;
   int                mismatches;
   int                pending;
   bit                long_hold_go = 0;
   bit                long_hold_done = 0;
   int                hold_left = 0;
   longint            cycles = 0;
   int                burst_left = 0;
   logic [VAL_W-1:0]  kept_vals [$];

   always #1 clock = ~clock;

   sorted_table_with_prime_view_top dut (.*);

   sorted_table_with_prime_view_checker chk (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("sorted_table_with_prime_view_top verification failed");
         $finish;
      end
   end

   // receiver stall pattern, with one long hold
   always @(posedge clock) begin
      if (long_hold_go && !long_hold_done) begin
         long_hold_done <= 1;
         hold_left <= 3000;
         rsp_ready <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 0;
      end else if ((cycles / 512) % 3 == 0) begin
         rsp_ready <= 1;
      end else begin
         rsp_ready <= ($urandom_range(0, 9) < 6);
      end
   end

   task automatic send_word(logic [FUNC_W-1:0] func, logic [VAL_W-1:0] val,
                            logic [POS_W-1:0] pos);
      int gap;
      if (burst_left == 0) begin
         req_valid <= 0;
         gap = $urandom_range(1, 12);
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_valid <= 1;
      req_func <= func;
      req_value <= val;
      req_position <= pos;
      do @(posedge clock); while (!req_ready);
      if (func == FUNC_INSERT && kept_vals.size() < 300) kept_vals = {kept_vals, val};
   endtask

   function automatic logic [VAL_W-1:0] pick_value();
      logic [VAL_W-1:0] v;
      int r;
      r = $urandom_range(0, 9);
      if (r <= 5) begin
         v = $urandom_range(0, 4000) - 1000;
      end else if (r <= 8 || kept_vals.size() == 0) begin
         v = $urandom;
         if (!v[VAL_W-1]) v[0] = 0;
      end else begin
         v = kept_vals[$urandom_range(0, kept_vals.size() - 1)];
      end
      return v;
   endfunction

   task automatic random_word(int insert_pct, int remove_pct);
      int r;
      int k;
      logic [VAL_W-1:0] v;
      r = $urandom_range(0, 99);
      if (r < insert_pct) begin
         send_word(FUNC_INSERT, pick_value(), POS_W'($urandom));
      end else if (r < insert_pct + remove_pct) begin
         if (kept_vals.size() > 0 && $urandom_range(0, 9) < 8) begin
            k = $urandom_range(0, kept_vals.size() - 1);
            v = kept_vals[k];
            kept_vals.delete(k);
         end else begin
            v = $urandom;
         end
         send_word(FUNC_REMOVE, v, POS_W'($urandom));
      end else begin
         r = $urandom_range(0, 30);
         send_word(r < 10 ? FUNC_READ_ASC : r < 20 ? FUNC_READ_SIDE :
                   r < 30 ? FUNC_READ_PRIME : 3'($urandom_range(5, 7)),
                   $urandom, POS_W'($urandom));
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_word(FUNC_READ_ASC, '0, '0);
      send_word(FUNC_READ_PRIME, '0, '0);
      send_word(FUNC_REMOVE, 32'd5, '0);
      send_word(FUNC_INSERT, 32'h8000_0000, 8'hff);
      send_word(FUNC_INSERT, 32'h7fff_fffe, '0);
      send_word(FUNC_INSERT, '0, '0);
      send_word(FUNC_INSERT, 32'd1, '0);
      send_word(FUNC_INSERT, 32'd2, '0);
      send_word(FUNC_INSERT, 32'hffff_ffff, '0);
      send_word(FUNC_INSERT, 32'd7, '0);
      send_word(FUNC_INSERT, 32'd7, '0);
      send_word(FUNC_INSERT, 32'd9, '0);
      send_word(FUNC_READ_ASC, '0, '0);
      send_word(FUNC_READ_ASC, '0, 8'hff);
      send_word(FUNC_READ_SIDE, '0, '0);
      send_word(FUNC_READ_SIDE, '0, 8'd1);
      send_word(FUNC_READ_SIDE, '0, 8'd2);
      send_word(FUNC_READ_SIDE, '0, 8'hff);
      send_word(FUNC_READ_PRIME, '0, 8'd1);
      send_word(FUNC_READ_PRIME, '0, 8'd200);
      send_word(FUNC_REMOVE, 32'd7, '0);
      send_word(FUNC_REMOVE, 32'd12345, '0);
      send_word(FUNC_SPARE_A, 32'hffff_ffff, 8'hff);
      send_word(FUNC_SPARE_B, '0, '0);
      send_word(FUNC_SPARE_C, 32'd1, 8'd1);
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i == 150) long_hold_go <= 1;
         if (i == 1000) begin
            // drain before refilling
            req_valid <= 0;
            burst_left = 0;
            @(posedge clock);
            wait (pending == 0);
            @(posedge clock);
         end
         if (i < 600) random_word(75, 10);
         else if (i < 1000) random_word(15, 60);
         else random_word(80, 5);
      end
      req_valid <= 0;
      @(posedge clock);
      wait (pending == 0);
      repeat (50) @(posedge clock);
      if (mismatches == 0 && pending == 0)
         $display("sorted_table_with_prime_view_top verification clean");
      else
         $display("sorted_table_with_prime_view_top verification failed");
      $finish;
   end
endmodule
`default_nettype wire
